// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define SSBG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spectral subtraction check failed");

// Antecedent in one cycle implies consequent in the next.
`define SSBG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spectral subtraction check failed");

`endif

// ===== hdl/ssbg_pkg.sv =====
// Types, constants and widths shared by the spectral subtraction block.
package ssbg_pkg;

  localparam int unsigned FFT_POINTS  = 4096;
  localparam int unsigned NOISE_BINS  = FFT_POINTS / 2 + 1;
  localparam int unsigned ADDR_W      = $clog2(NOISE_BINS);

  localparam int unsigned BIN_W       = 12;
  localparam int unsigned DATA_W      = 24;
  localparam int unsigned MAG_W       = 24;
  localparam int unsigned SQ_W        = 2 * MAG_W + 1;
  localparam int unsigned PRINT_W     = 25;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned OS_W        = 15;
  localparam int unsigned FC_W        = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_W       = OS_W + PRINT_W + 3;
  localparam int unsigned REM_W       = SQ_W;
  localparam int unsigned Q_W         = 25;
  localparam int unsigned SQRT_STEPS  = 25;
  localparam int unsigned DIV_STEPS   = Q_W;
  localparam int unsigned PROD_W      = DATA_W + GAIN_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(SQRT_STEPS + DIV_STEPS + 8) + 1;

  localparam logic [GAIN_W-1:0]  UNITY_GAIN = 16'd32768;
  localparam logic [PRINT_W-1:0] PRINT_MAX  = '1;
  localparam logic [BIN_W-1:0]   LAST_BIN   = BIN_W'(NOISE_BINS - 1);

  localparam logic [OS_W-1:0]    OVERSUB_RST = 15'd8192;
  localparam logic [GAIN_W-1:0]  FLOOR_RST   = 16'd0;
  localparam logic [FC_W-1:0]    FRAMES_RST  = 16'd1;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_PASS = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERSUB = 2'd0,
    CFG_FLOOR   = 2'd1,
    CFG_FRAMES  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e                       op;
    logic [BIN_W-1:0]          bin;
    logic signed [DATA_W-1:0]  re;
    logic signed [DATA_W-1:0]  im;
  } item_t;

  typedef struct packed {
    op_e                       op;
    logic [BIN_W-1:0]          bin;
    logic signed [DATA_W-1:0]  re;
    logic signed [DATA_W-1:0]  im;
    logic [PRINT_W-1:0]        noise;
    logic                      mz;
  } ctx_t;

  typedef struct packed {
    logic [OS_W-1:0]   oversub;
    logic [GAIN_W-1:0] floor_g;
    logic [FC_W-1:0]   frames;
  } cfg_t;

endpackage

// ===== hdl/ssbg_front.sv =====
// Input stage: accepts items and classifies them into store operations.
module ssbg_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic                               command_i,
  input  logic                               first_frame_i,
  input  logic [ssbg_pkg::BIN_W-1:0]         bin_index_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0] bin_real_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0] bin_imag_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output ssbg_pkg::item_t                    q_item_o
);

  logic            fr_vld_q;
  ssbg_pkg::item_t fr_item_q;
  ssbg_pkg::item_t cls;

  always_comb begin
    cls.bin = bin_index_i;
    cls.re  = bin_real_i;
    cls.im  = bin_imag_i;
    if (bin_index_i > ssbg_pkg::LAST_BIN) begin
      cls.op = ssbg_pkg::OP_PASS;
    end else if (command_i) begin
      cls.op = ssbg_pkg::OP_SUB;
    end else if (first_frame_i) begin
      cls.op = ssbg_pkg::OP_SET;
    end else begin
      cls.op = ssbg_pkg::OP_ADD;
    end
  end

  // stage can load whenever it is empty or its item moves on
  assign full_o   = fr_vld_q && q_full_i;
  assign q_push_o = fr_vld_q && !q_full_i;
  assign q_item_o = fr_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else if (!full_o) begin
      fr_vld_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      fr_item_q <= cls;
    end
  end

endmodule

// ===== hdl/ssbg_queue.sv =====
// Short item queue between the front and the back.
module ssbg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ssbg_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            vld_o,
  output ssbg_pkg::item_t item_o
);

  ssbg_pkg::item_t                slot_q [ssbg_pkg::QUEUE_DEPTH];
  logic [ssbg_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [ssbg_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [ssbg_pkg::QPTR_W:0]      cnt_q;
  logic [ssbg_pkg::QPTR_W:0]      cnt_d;

  assign full_o = (cnt_q == (ssbg_pkg::QPTR_W + 1)'(ssbg_pkg::QUEUE_DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign item_o = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/ssbg_mag.sv =====
// Pipelined magnitude: squares, sum, then one root digit per stage.
module ssbg_mag (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  ssbg_pkg::ctx_t              ctx_i,
  output logic                        vld_o,
  output ssbg_pkg::ctx_t              ctx_o,
  output logic [ssbg_pkg::MAG_W-1:0]  mag_o
);

  localparam int unsigned N = ssbg_pkg::SQRT_STEPS;

  logic [ssbg_pkg::DATA_W-1:0]  are;
  logic [ssbg_pkg::DATA_W-1:0]  aim;
  logic [2*ssbg_pkg::MAG_W-1:0] sqr_d;
  logic [2*ssbg_pkg::MAG_W-1:0] sqi_d;
  logic [2*ssbg_pkg::MAG_W-1:0] sqr_q;
  logic [2*ssbg_pkg::MAG_W-1:0] sqi_q;
  logic                         s1_vld_q;
  ssbg_pkg::ctx_t               s1_ctx_q;

  logic                         st_vld_q [N+1];
  ssbg_pkg::ctx_t               st_ctx_q [N+1];
  logic [ssbg_pkg::SQ_W-1:0]    st_rem_q [N+1];
  logic [ssbg_pkg::SQ_W-1:0]    st_res_q [N+1];

  assign are   = ctx_i.re[ssbg_pkg::DATA_W-1] ? (~ctx_i.re + 24'd1) : ctx_i.re;
  assign aim   = ctx_i.im[ssbg_pkg::DATA_W-1] ? (~ctx_i.im + 24'd1) : ctx_i.im;
  assign sqr_d = are * are;
  assign sqi_d = aim * aim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      st_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      s1_vld_q    <= vld_i;
      st_vld_q[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ctx_q    <= ctx_i;
      sqr_q       <= sqr_d;
      sqi_q       <= sqi_d;
      st_ctx_q[0] <= s1_ctx_q;
      st_rem_q[0] <= {1'b0, sqr_q} + {1'b0, sqi_q};
      st_res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int unsigned SH = 2 * (N - 1 - k);
    logic [ssbg_pkg::SQ_W-1:0] bitv;
    logic [ssbg_pkg::SQ_W-1:0] trial;

    assign bitv  = ssbg_pkg::SQ_W'(1) << SH;
    assign trial = st_res_q[k] + bitv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        st_vld_q[k+1] <= st_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_ctx_q[k+1] <= st_ctx_q[k];
        if (st_rem_q[k] >= trial) begin
          st_rem_q[k+1] <= st_rem_q[k] - trial;
          st_res_q[k+1] <= (st_res_q[k] >> 1) + bitv;
        end else begin
          st_rem_q[k+1] <= st_rem_q[k];
          st_res_q[k+1] <= st_res_q[k] >> 1;
        end
      end
    end
  end

  assign vld_o = st_vld_q[N];
  assign ctx_o = st_ctx_q[N];
  assign mag_o = st_res_q[N][ssbg_pkg::MAG_W-1:0];

endmodule

// ===== hdl/ssbg_div.sv =====
// Pipelined rounded divider, one quotient bit per stage, with overflow flag.
module ssbg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  ssbg_pkg::ctx_t              ctx_i,
  input  logic [ssbg_pkg::NUM_W-1:0]  dend_i,
  input  logic [ssbg_pkg::MAG_W-1:0]  dsor_i,
  output logic                        vld_o,
  output ssbg_pkg::ctx_t              ctx_o,
  output logic [ssbg_pkg::Q_W-1:0]    quo_o,
  output logic                        sat_o
);

  localparam int unsigned N = ssbg_pkg::DIV_STEPS;

  logic [ssbg_pkg::REM_W-1:0] p_rem;
  logic                       p_sat;

  logic                       st_vld_q  [N+1];
  ssbg_pkg::ctx_t             st_ctx_q  [N+1];
  logic [ssbg_pkg::REM_W-1:0] st_rem_q  [N+1];
  logic [ssbg_pkg::Q_W-1:0]   st_quo_q  [N+1];
  logic                       st_sat_q  [N+1];
  logic [ssbg_pkg::MAG_W-1:0] st_dsor_q [N+1];

  // add half the divisor for round to nearest; quotient beyond Q_W bits saturates
  assign p_rem = ssbg_pkg::REM_W'(dend_i) + ssbg_pkg::REM_W'(dsor_i >> 1);
  assign p_sat = (p_rem >= (ssbg_pkg::REM_W'(dsor_i) << ssbg_pkg::Q_W));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      st_vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_ctx_q[0]  <= ctx_i;
      st_rem_q[0]  <= p_rem;
      st_quo_q[0]  <= '0;
      st_sat_q[0]  <= p_sat;
      st_dsor_q[0] <= dsor_i;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int unsigned SH = N - 1 - k;
    logic [ssbg_pkg::REM_W-1:0] trial;

    assign trial = ssbg_pkg::REM_W'(st_dsor_q[k]) << SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        st_vld_q[k+1] <= st_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_ctx_q[k+1]  <= st_ctx_q[k];
        st_sat_q[k+1]  <= st_sat_q[k];
        st_dsor_q[k+1] <= st_dsor_q[k];
        if (st_rem_q[k] >= trial) begin
          st_rem_q[k+1] <= st_rem_q[k] - trial;
          st_quo_q[k+1] <= st_quo_q[k] | (ssbg_pkg::Q_W'(1) << SH);
        end else begin
          st_rem_q[k+1] <= st_rem_q[k];
          st_quo_q[k+1] <= st_quo_q[k];
        end
      end
    end
  end

  assign vld_o = st_vld_q[N];
  assign ctx_o = st_ctx_q[N];
  assign quo_o = st_quo_q[N];
  assign sat_o = st_sat_q[N];

endmodule

// ===== hdl/ssbg_back.sv =====
// Execution pipeline: noise store, magnitude, divide, gain and scaling.
module ssbg_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssbg_pkg::cfg_t                     cfg_i,
  input  logic                               q_vld_i,
  input  ssbg_pkg::item_t                    q_item_i,
  output logic                               q_pop_o,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic signed [ssbg_pkg::DATA_W-1:0] out_real_o,
  output logic signed [ssbg_pkg::DATA_W-1:0] out_imag_o,
  output logic [ssbg_pkg::GAIN_W-1:0]        applied_gain_o
);

  logic adv;
  logic take;
  logic is_cap_in;

  logic [ssbg_pkg::PRINT_W-1:0] noise_mem_q [ssbg_pkg::NOISE_BINS];
  logic [ssbg_pkg::CNT_W-1:0]   cap_cnt_q;
  logic [ssbg_pkg::CNT_W-1:0]   cap_cnt_d;

  logic                         e_vld_q;
  ssbg_pkg::item_t              e_item_q;
  logic [ssbg_pkg::PRINT_W-1:0] rd1_q;
  ssbg_pkg::ctx_t               m_ctx_i;

  logic                         m_vld;
  ssbg_pkg::ctx_t               m_ctx;
  logic [ssbg_pkg::MAG_W-1:0]   m_mag;

  logic [ssbg_pkg::OS_W+ssbg_pkg::PRINT_W-1:0] num;
  logic [ssbg_pkg::FC_W-1:0]    fc_eff;
  ssbg_pkg::ctx_t               d_ctx_d;
  logic [ssbg_pkg::NUM_W-1:0]   d_dend_d;
  logic [ssbg_pkg::MAG_W-1:0]   d_dsor_d;
  logic                         d_vld_q;
  ssbg_pkg::ctx_t               d_ctx_q;
  logic [ssbg_pkg::NUM_W-1:0]   d_dend_q;
  logic [ssbg_pkg::MAG_W-1:0]   d_dsor_q;

  logic                         v_vld;
  ssbg_pkg::ctx_t               v_ctx;
  logic [ssbg_pkg::Q_W-1:0]     v_quo;
  logic                         v_sat;

  logic                         e1_vld_q;
  ssbg_pkg::ctx_t               e1_ctx_q;
  logic [ssbg_pkg::Q_W-1:0]     e1_quo_q;
  logic                         e1_sat_q;
  logic [ssbg_pkg::PRINT_W-1:0] rd2_q;
  logic                         wr_vld_q;
  logic [ssbg_pkg::BIN_W-1:0]   wr_bin_q;
  logic [ssbg_pkg::PRINT_W-1:0] wr_val_q;
  logic [ssbg_pkg::PRINT_W-1:0] old_val;
  logic [ssbg_pkg::PRINT_W-1:0] base_val;
  logic [ssbg_pkg::PRINT_W:0]   sum_val;
  logic [ssbg_pkg::PRINT_W-1:0] new_val;
  logic                         do_wr;
  logic [ssbg_pkg::GAIN_W-1:0]  fl;
  logic [ssbg_pkg::GAIN_W-1:0]  g0;
  logic [ssbg_pkg::GAIN_W-1:0]  gsub;
  logic [ssbg_pkg::GAIN_W-1:0]  gain;

  logic                         e2_vld_q;
  logic signed [ssbg_pkg::DATA_W-1:0] e2_re_q;
  logic signed [ssbg_pkg::DATA_W-1:0] e2_im_q;
  logic [ssbg_pkg::GAIN_W-1:0]  e2_gain_q;
  logic [ssbg_pkg::DATA_W-1:0]  abs_re;
  logic [ssbg_pkg::DATA_W-1:0]  abs_im;

  logic                         e3_vld_q;
  logic [ssbg_pkg::PROD_W-1:0]  e3_pre_q;
  logic [ssbg_pkg::PROD_W-1:0]  e3_pim_q;
  logic                         e3_neg_re_q;
  logic                         e3_neg_im_q;
  logic [ssbg_pkg::GAIN_W-1:0]  e3_gain_q;
  logic [ssbg_pkg::PROD_W-1:0]  rs_re;
  logic [ssbg_pkg::PROD_W-1:0]  rs_im;
  logic [ssbg_pkg::DATA_W:0]    r_re;
  logic [ssbg_pkg::DATA_W:0]    r_im;
  logic [ssbg_pkg::DATA_W:0]    s_re;
  logic [ssbg_pkg::DATA_W:0]    s_im;

  logic                         out_vld_q;
  logic signed [ssbg_pkg::DATA_W-1:0] out_re_q;
  logic signed [ssbg_pkg::DATA_W-1:0] out_im_q;
  logic [ssbg_pkg::GAIN_W-1:0]  out_gain_q;

  // whole pipeline moves as one whenever the output register frees up
  assign adv = !out_vld_q || pop_i;

  // a subtract reads the store up front, so it waits for earlier captures
  assign is_cap_in = (q_item_i.op == ssbg_pkg::OP_SET) || (q_item_i.op == ssbg_pkg::OP_ADD);
  assign take = adv && q_vld_i &&
                ((q_item_i.op != ssbg_pkg::OP_SUB) || (cap_cnt_q == '0));
  assign q_pop_o = take;

  always_comb begin
    cap_cnt_d = cap_cnt_q;
    if ((take && is_cap_in) && !(adv && do_wr)) begin
      cap_cnt_d = cap_cnt_q + 1'b1;
    end else if (!(take && is_cap_in) && (adv && do_wr)) begin
      cap_cnt_d = cap_cnt_q - 1'b1;
    end
  end

  // entry stage with the early store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q   <= 1'b0;
      cap_cnt_q <= '0;
    end else begin
      cap_cnt_q <= cap_cnt_d;
      if (adv) begin
        e_vld_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_item_q <= q_item_i;
      if (take && (q_item_i.op == ssbg_pkg::OP_SUB)) begin
        rd1_q <= noise_mem_q[q_item_i.bin[ssbg_pkg::ADDR_W-1:0]];
      end
    end
  end

  always_comb begin
    m_ctx_i.op    = e_item_q.op;
    m_ctx_i.bin   = e_item_q.bin;
    m_ctx_i.re    = e_item_q.re;
    m_ctx_i.im    = e_item_q.im;
    m_ctx_i.noise = rd1_q;
    m_ctx_i.mz    = 1'b0;
  end

  ssbg_mag u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (e_vld_q),
    .ctx_i  (m_ctx_i),
    .vld_o  (m_vld),
    .ctx_o  (m_ctx),
    .mag_o  (m_mag)
  );

  // divider operands: alpha*noise*8 / mag, or mag / frame count
  assign num    = m_ctx.noise * cfg_i.oversub;
  assign fc_eff = (cfg_i.frames == '0) ? ssbg_pkg::FC_W'(1) : cfg_i.frames;

  always_comb begin
    d_ctx_d    = m_ctx;
    d_ctx_d.mz = (m_mag == '0);
    if (m_ctx.op == ssbg_pkg::OP_SUB) begin
      d_dend_d = {num, 3'b000};
      d_dsor_d = m_mag;
    end else begin
      d_dend_d = ssbg_pkg::NUM_W'(m_mag);
      d_dsor_d = ssbg_pkg::MAG_W'(fc_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= m_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_ctx_q  <= d_ctx_d;
      d_dend_q <= d_dend_d;
      d_dsor_q <= d_dsor_d;
    end
  end

  ssbg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (d_vld_q),
    .ctx_i  (d_ctx_q),
    .dend_i (d_dend_q),
    .dsor_i (d_dsor_q),
    .vld_o  (v_vld),
    .ctx_o  (v_ctx),
    .quo_o  (v_quo),
    .sat_o  (v_sat)
  );

  // store update; the entry written on the same edge as the read is forwarded
  assign old_val  = (wr_vld_q && (wr_bin_q == e1_ctx_q.bin)) ? wr_val_q : rd2_q;
  assign base_val = (e1_ctx_q.op == ssbg_pkg::OP_SET) ? '0 : old_val;
  assign sum_val  = (ssbg_pkg::PRINT_W + 1)'(base_val) + (ssbg_pkg::PRINT_W + 1)'(e1_quo_q);
  assign new_val  = (sum_val > (ssbg_pkg::PRINT_W + 1)'(ssbg_pkg::PRINT_MAX)) ?
                    ssbg_pkg::PRINT_MAX : sum_val[ssbg_pkg::PRINT_W-1:0];
  assign do_wr    = e1_vld_q && ((e1_ctx_q.op == ssbg_pkg::OP_SET) ||
                                 (e1_ctx_q.op == ssbg_pkg::OP_ADD));

  // gain = max(floor, unity - t), unity for captures, pass and zero magnitude
  assign fl   = (cfg_i.floor_g > ssbg_pkg::UNITY_GAIN) ? ssbg_pkg::UNITY_GAIN : cfg_i.floor_g;
  assign g0   = (e1_sat_q || (e1_quo_q >= ssbg_pkg::Q_W'(ssbg_pkg::UNITY_GAIN))) ? '0 :
                ssbg_pkg::UNITY_GAIN - e1_quo_q[ssbg_pkg::GAIN_W-1:0];
  assign gsub = (g0 < fl) ? fl : g0;
  assign gain = ((e1_ctx_q.op == ssbg_pkg::OP_SUB) && !e1_ctx_q.mz) ? gsub :
                ssbg_pkg::UNITY_GAIN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
      e2_vld_q  <= 1'b0;
      e3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      e1_vld_q  <= v_vld;
      wr_vld_q  <= do_wr;
      e2_vld_q  <= e1_vld_q;
      e3_vld_q  <= e2_vld_q;
      out_vld_q <= e3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_ctx_q <= v_ctx;
      e1_quo_q <= v_quo;
      e1_sat_q <= v_sat;
      if (v_vld && (v_ctx.op == ssbg_pkg::OP_ADD)) begin
        rd2_q <= noise_mem_q[v_ctx.bin[ssbg_pkg::ADDR_W-1:0]];
      end
      if (do_wr) begin
        noise_mem_q[e1_ctx_q.bin[ssbg_pkg::ADDR_W-1:0]] <= new_val;
      end
      wr_bin_q <= e1_ctx_q.bin;
      wr_val_q <= new_val;
    end
  end

  // scaling: magnitude times gain, round half away from zero, sign back
  assign abs_re = e2_re_q[ssbg_pkg::DATA_W-1] ? (~e2_re_q + 24'd1) : e2_re_q;
  assign abs_im = e2_im_q[ssbg_pkg::DATA_W-1] ? (~e2_im_q + 24'd1) : e2_im_q;

  assign rs_re = e3_pre_q + (ssbg_pkg::PROD_W'(1) << (ssbg_pkg::GAIN_W - 2));
  assign rs_im = e3_pim_q + (ssbg_pkg::PROD_W'(1) << (ssbg_pkg::GAIN_W - 2));
  assign r_re  = rs_re[ssbg_pkg::PROD_W-1:ssbg_pkg::GAIN_W-1];
  assign r_im  = rs_im[ssbg_pkg::PROD_W-1:ssbg_pkg::GAIN_W-1];
  assign s_re  = e3_neg_re_q ? (~r_re + 1'b1) : r_re;
  assign s_im  = e3_neg_im_q ? (~r_im + 1'b1) : r_im;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_re_q     <= e1_ctx_q.re;
      e2_im_q     <= e1_ctx_q.im;
      e2_gain_q   <= gain;
      e3_pre_q    <= abs_re * e2_gain_q;
      e3_pim_q    <= abs_im * e2_gain_q;
      e3_neg_re_q <= e2_re_q[ssbg_pkg::DATA_W-1];
      e3_neg_im_q <= e2_im_q[ssbg_pkg::DATA_W-1];
      e3_gain_q   <= e2_gain_q;
      out_re_q    <= s_re[ssbg_pkg::DATA_W-1:0];
      out_im_q    <= s_im[ssbg_pkg::DATA_W-1:0];
      out_gain_q  <= e3_gain_q;
    end
  end

  assign empty_o        = !out_vld_q;
  assign out_real_o     = out_re_q;
  assign out_imag_o     = out_im_q;
  assign applied_gain_o = out_gain_q;

endmodule

// ===== hdl/spectral_subtraction_bin_gain_top.sv =====
// Top level of the per-bin spectral subtraction gain block.
// Spectral subtraction, one STFT bin per item. A capture item (command 0)
// adds round(|X| / frame_count) into the noise print entry of its bin, or
// overwrites it on the first frame; the bin comes back unchanged with gain
// 32768 (unity in Q1.15). A subtract item (command 1) gets the gain
// max(floor, 1 - alpha * noise / |X|), unity when |X| is zero, and both
// parts are scaled by it with round half away from zero. Bins above half
// the FFT size pass through with unity gain and leave the store alone.
// Rate: one item per clock sustained in either mode while results are popped;
// the 25-stage root, 26-stage rounding divider, the store read/update and
// the scaling multipliers all advance together. A subtract reads the noise
// print as it enters the pipeline, while a capture writes its entry only
// after the divider, so the first subtract behind captures waits until
// those captures have drained, once per switch from capture to subtract.
// The noise print holds garbage after reset; capture with first_frame set
// before subtracting on a bin. There is no clearing pass. Registers are
// written through the cfg channel, which is always ready, and must only be
// changed while no item is in flight.
module spectral_subtraction_bin_gain_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                command_i,
  input  logic                                first_frame_i,
  input  logic [ssbg_pkg::BIN_W-1:0]          bin_index_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0]  bin_real_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0]  bin_imag_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [ssbg_pkg::DATA_W-1:0]  out_real_o,
  output logic signed [ssbg_pkg::DATA_W-1:0]  out_imag_o,
  output logic [ssbg_pkg::GAIN_W-1:0]         applied_gain_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ssbg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ssbg_pkg::CFG_W-1:0]          cfg_data_i
);

  ssbg_pkg::cfg_t  cfg_q;
  logic            q_push;
  ssbg_pkg::item_t q_item_in;
  logic            q_full;
  logic            q_vld;
  ssbg_pkg::item_t q_item;
  logic            q_pop;

  // config registers; writes to an unused index are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oversub <= ssbg_pkg::OVERSUB_RST;
      cfg_q.floor_g <= ssbg_pkg::FLOOR_RST;
      cfg_q.frames  <= ssbg_pkg::FRAMES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ssbg_pkg::cfg_idx_e'(cfg_index_i))
        ssbg_pkg::CFG_OVERSUB: cfg_q.oversub <= cfg_data_i[ssbg_pkg::OS_W-1:0];
        ssbg_pkg::CFG_FLOOR:   cfg_q.floor_g <= cfg_data_i[ssbg_pkg::GAIN_W-1:0];
        ssbg_pkg::CFG_FRAMES:  cfg_q.frames  <= cfg_data_i[ssbg_pkg::FC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: input register and classification
  ssbg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .command_i     (command_i),
    .first_frame_i (first_frame_i),
    .bin_index_i   (bin_index_i),
    .bin_real_i    (bin_real_i),
    .bin_imag_i    (bin_imag_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_item_in)
  );

  // decoupling queue
  ssbg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .item_o (q_item)
  );

  // back: store, magnitude, divide, gain, scaling, output register
  ssbg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_vld_i        (q_vld),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_real_o     (out_real_o),
    .out_imag_o     (out_imag_o),
    .applied_gain_o (applied_gain_o)
  );

endmodule

// ===== hdl/ssbg_checker.sv =====
// Port-level checker for the spectral subtraction block, with its bind.
`include "assert_macros.svh"

module ssbg_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               empty,
  input logic                               pop,
  input logic signed [ssbg_pkg::DATA_W-1:0] out_real_o,
  input logic signed [ssbg_pkg::DATA_W-1:0] out_imag_o,
  input logic [ssbg_pkg::GAIN_W-1:0]        applied_gain_o
);

  // a waiting result is neither dropped nor changed
  `SSBG_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)
  `SSBG_ASSERT_NEXT(a_result_stable, !empty && !pop,
                    $stable(out_real_o) && $stable(out_imag_o) && $stable(applied_gain_o))
  // gain never exceeds unity
  `SSBG_ASSERT(a_gain_range, !empty |-> (applied_gain_o <= ssbg_pkg::UNITY_GAIN))
  // zero gain silences the bin
  `SSBG_ASSERT(a_zero_gain,
               (!empty && (applied_gain_o == '0)) |-> ((out_real_o == '0) && (out_imag_o == '0)))

endmodule

bind spectral_subtraction_bin_gain_top ssbg_checker u_ssbg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .out_real_o     (out_real_o),
  .out_imag_o     (out_imag_o),
  .applied_gain_o (applied_gain_o)
);

// ===== bench/ssbg_checker.sv =====
// Checker for the spectral subtraction block: predicts each result and compares it.
module ssbg_scoreboard (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic                                 full_i,
  input  logic                                 command_i,
  input  logic                                 first_frame_i,
  input  logic [ssbg_pkg::BIN_W-1:0]           bin_index_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0]   bin_real_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0]   bin_imag_i,
  input  logic                                 empty_i,
  input  logic                                 pop_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0]   out_real_i,
  input  logic signed [ssbg_pkg::DATA_W-1:0]   out_imag_i,
  input  logic [ssbg_pkg::GAIN_W-1:0]          applied_gain_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [ssbg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ssbg_pkg::CFG_W-1:0]           cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   results_seen_o
);

  typedef struct packed {
    logic signed [ssbg_pkg::DATA_W-1:0] re;
    logic signed [ssbg_pkg::DATA_W-1:0] im;
    logic [ssbg_pkg::GAIN_W-1:0]        gain;
  } bin_out_t;

  bin_out_t                     gain_expect_q[$];
  logic [ssbg_pkg::PRINT_W-1:0] noise_mem[ssbg_pkg::NOISE_BINS];
  logic [ssbg_pkg::OS_W-1:0]    alpha_q;
  logic [ssbg_pkg::GAIN_W-1:0]  floor_q;
  logic [ssbg_pkg::FC_W-1:0]    frames_q;

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 48;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [ssbg_pkg::DATA_W-1:0] scale_part(
      logic signed [ssbg_pkg::DATA_W-1:0] x, logic [ssbg_pkg::GAIN_W-1:0] g);
    logic [63:0] m, r;
    m = x < 0 ? 64'(-65'(x)) : 64'(x);
    r = (m * g + 64'd16384) >> 15;
    return x < 0 ? ssbg_pkg::DATA_W'(-r) : ssbg_pkg::DATA_W'(r);
  endfunction

  function automatic bin_out_t predict_bin(logic cmd, logic first,
                                           logic [ssbg_pkg::BIN_W-1:0] bin,
                                           logic signed [ssbg_pkg::DATA_W-1:0] re,
                                           logic signed [ssbg_pkg::DATA_W-1:0] im);
    logic [63:0] are, aim, mag, fc, add, sum, fl, num, t, g;
    bin_out_t o;
    are = re < 0 ? 64'(-65'(re)) : 64'(re);
    aim = im < 0 ? 64'(-65'(im)) : 64'(im);
    mag = root_floor(are * are + aim * aim);
    g = 64'(ssbg_pkg::UNITY_GAIN);
    if (bin < ssbg_pkg::NOISE_BINS) begin
      if (!cmd) begin
        fc = frames_q == 0 ? 64'd1 : 64'(frames_q);
        add = (mag + fc / 2) / fc;
        sum = first ? add : 64'(noise_mem[bin]) + add;
        if (sum > 64'(ssbg_pkg::PRINT_MAX)) sum = 64'(ssbg_pkg::PRINT_MAX);
        noise_mem[bin] = ssbg_pkg::PRINT_W'(sum);
      end else if (mag > 0) begin
        fl = floor_q > ssbg_pkg::UNITY_GAIN ? 64'(ssbg_pkg::UNITY_GAIN) : 64'(floor_q);
        num = 64'(alpha_q) * 64'(noise_mem[bin]) * 64'd8;
        t = (num + mag / 2) / mag;
        g = t >= 64'(ssbg_pkg::UNITY_GAIN) ? 64'd0 : 64'(ssbg_pkg::UNITY_GAIN) - t;
        if (g < fl) g = fl;
      end
    end
    o.gain = ssbg_pkg::GAIN_W'(g);
    o.re = scale_part(re, o.gain);
    o.im = scale_part(im, o.gain);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_out_t e;
    if (!rst_ni) begin
      alpha_q <= ssbg_pkg::OVERSUB_RST;
      floor_q <= ssbg_pkg::FLOOR_RST;
      frames_q <= ssbg_pkg::FRAMES_RST;
      fail_count_o <= 0;
      results_seen_o <= 0;
      pending_o <= 0;
      gain_expect_q.delete();
      for (int k = 0; k < ssbg_pkg::NOISE_BINS; k++) noise_mem[k] = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ssbg_pkg::CFG_OVERSUB: alpha_q <= ssbg_pkg::OS_W'(cfg_data_i);
          ssbg_pkg::CFG_FLOOR:   floor_q <= cfg_data_i;
          ssbg_pkg::CFG_FRAMES:  frames_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i)
        gain_expect_q.push_back(predict_bin(command_i, first_frame_i, bin_index_i,
                                            bin_real_i, bin_imag_i));
      if (pop_i && !empty_i) begin
        results_seen_o <= results_seen_o + 1;
        if (gain_expect_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result re=%0d im=%0d gain=%0d",
                                          out_real_i, out_imag_i, applied_gain_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = gain_expect_q.pop_front();
          if (e.re !== out_real_i || e.im !== out_imag_i || e.gain !== applied_gain_i) begin
            if (fail_count_o < 10)
              $display("mismatch: exp re=%0d im=%0d gain=%0d, got re=%0d im=%0d gain=%0d",
                       e.re, e.im, e.gain, out_real_i, out_imag_i, applied_gain_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= gain_expect_q.size();
    end
  end

endmodule

// ===== bench/spectral_subtraction_bin_gain_top_tb.sv =====
// Testbench top: stimulus, configuration phases and the verdict.
module spectral_subtraction_bin_gain_top_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0, command_i = 1'b0, first_frame_i = 1'b0, pop = 1'b0;
  logic [ssbg_pkg::BIN_W-1:0] bin_index_i = '0;
  logic signed [ssbg_pkg::DATA_W-1:0] bin_real_i = '0, bin_imag_i = '0;
  logic full, empty, cfg_ready_o;
  logic signed [ssbg_pkg::DATA_W-1:0] out_real_o, out_imag_o;
  logic [ssbg_pkg::GAIN_W-1:0] applied_gain_o;
  logic cfg_valid_i = 1'b0;
  logic [ssbg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ssbg_pkg::CFG_W-1:0] cfg_data_i = '0;
  int fail_count, pending, results_seen;
  int items_sent = 0;
  // Bins written by a first-frame capture; only these may be read.
  bit primed[ssbg_pkg::NOISE_BINS];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  spectral_subtraction_bin_gain_top dut (
    .clk_i, .rst_ni, .push, .full, .command_i, .first_frame_i, .bin_index_i,
    .bin_real_i, .bin_imag_i, .empty, .pop, .out_real_o, .out_imag_o,
    .applied_gain_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  ssbg_scoreboard chk (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .command_i, .first_frame_i,
    .bin_index_i, .bin_real_i, .bin_imag_i, .empty_i(empty), .pop_i(pop),
    .out_real_i(out_real_o), .out_imag_i(out_imag_o), .applied_gain_i(applied_gain_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Sink side: a random stall before each pop.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) w = 0;
      pop = 1'b0;
      repeat (w) @(negedge clk_i);
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // One item with a random gap in front; holds push until accepted.
  task automatic send_bin(logic cmd, logic first, logic [ssbg_pkg::BIN_W-1:0] bin,
                          logic signed [ssbg_pkg::DATA_W-1:0] re,
                          logic signed [ssbg_pkg::DATA_W-1:0] im);
    int w;
    w = $urandom_range(0, 3);
    if (w > 0) begin
      push <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    first_frame_i <= first;
    bin_index_i <= bin;
    bin_real_i <= re;
    bin_imag_i <= im;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    if (bin < ssbg_pkg::NOISE_BINS && !cmd && first) primed[bin] = 1;
    items_sent++;
  endtask

  // Drain everything, then wait out the pipeline before touching registers.
  task automatic drain_pipe();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(ssbg_pkg::cfg_idx_e idx, logic [ssbg_pkg::CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [ssbg_pkg::DATA_W-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return ssbg_pkg::DATA_W'(int'($urandom_range(0, 15)) - 8);
      3: return ssbg_pkg::DATA_W'(int'($urandom_range(0, 8191)) - 4096);
      default: return ssbg_pkg::DATA_W'($urandom);
    endcase
  endfunction

  // Random bin: the last in-range bin, an out-of-range bin, bin zero, or one of bins 0 to 63.
  function automatic logic [ssbg_pkg::BIN_W-1:0] rand_bin();
    case ($urandom_range(0, 9))
      0: return ssbg_pkg::LAST_BIN;
      1: return ssbg_pkg::BIN_W'($urandom_range(ssbg_pkg::NOISE_BINS, 4095));
      2: return '0;
      default: return ssbg_pkg::BIN_W'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [ssbg_pkg::BIN_W-1:0] b;
    logic cmd, first;
    for (int i = 0; i < n; i++) begin
      b = rand_bin();
      cmd = $urandom_range(0, 2) != 0;
      first = 1'($urandom_range(0, 1));
      // Never read an entry that was never written.
      if (b < ssbg_pkg::NOISE_BINS && !primed[b] && (cmd || !first)) begin
        cmd = 1'b0;
        first = 1'b1;
      end
      send_bin(cmd, first, b, rand_part(), rand_part());
    end
  endtask

  initial begin
    logic [ssbg_pkg::CFG_W-1:0] os_v, fl_v, fc_v;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: defaults, extremes, zero magnitude, out-of-range bin, saturation.
    send_bin(1'b0, 1'b1, '0, 24'sh7FFFFF, 24'sh7FFFFF);
    send_bin(1'b0, 1'b0, '0, 24'sh800000, 24'sh800000);
    send_bin(1'b0, 1'b1, ssbg_pkg::LAST_BIN, 24'sd1000, -24'sd1000);
    send_bin(1'b1, 1'b0, ssbg_pkg::LAST_BIN, 24'sd0, 24'sd0);
    send_bin(1'b1, 1'b1, ssbg_pkg::LAST_BIN, 24'sd3000, 24'sd4000);
    send_bin(1'b1, 1'b0, 12'hFFF, 24'sh800000, 24'sh7FFFFF);
    send_bin(1'b0, 1'b1, ssbg_pkg::BIN_W'(ssbg_pkg::NOISE_BINS), 24'sd5, 24'sd5);
    send_bin(1'b1, 1'b0, '0, 24'sd1, -24'sd1);
    send_bin(1'b1, 1'b0, '0, 24'sh7FFFFF, 24'sh800000);
    for (int k = 0; k < 8; k++)
      send_bin(1'b0, 1'b0, '0, 24'sh7FFFFF, 24'sh800000); // drive the store to saturation
    send_bin(1'b1, 1'b0, '0, 24'sh7FFFFF, 24'sh7FFFFF);
    drain_pipe();

    // Register phases: extremes first, zero frame count and floor above unity included.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin os_v = 16'd0;     fl_v = 16'd0;     fc_v = 16'd1;     end
        1: begin os_v = 16'd27307; fl_v = 16'd32768; fc_v = 16'd65535; end
        2: begin os_v = 16'h7FFF;  fl_v = 16'hFFFF;  fc_v = 16'd0;     end
        3: begin os_v = 16'd27307; fl_v = 16'd0;     fc_v = 16'd2;     end
        4: begin os_v = 16'hFFFF;  fl_v = 16'h4000;  fc_v = 16'h8000;  end
        default: begin
          os_v = ssbg_pkg::CFG_W'($urandom_range(0, 27307));
          fl_v = ssbg_pkg::CFG_W'($urandom_range(0, 32768));
          fc_v = ssbg_pkg::CFG_W'($urandom_range(1, 16));
        end
      endcase
      write_reg(ssbg_pkg::CFG_OVERSUB, os_v);
      write_reg(ssbg_pkg::CFG_FLOOR, fl_v);
      write_reg(ssbg_pkg::CFG_FRAMES, fc_v);
      random_phase(100);
      drain_pipe();
    end

    $display("Covered %0d items over 10 register settings, %0d results checked.",
             items_sent, results_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
